/* rtl/tsbi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tsbi_pkg;

  // Fraction bits of all Q-format values.
  localparam int FRAC_BITS = 16;

  // Reset values of the query registers and of the scan state.
  localparam logic [31:0] MINUS_ONE = 32'(-(64'sd1 <<< FRAC_BITS));
  localparam logic [31:0] QUERY_ANGLE_RESET = 32'(((64'd211 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [31:0] QUERY_W2_RESET = 32'(64'd5 << FRAC_BITS);
  localparam logic [30:0] TOLERANCE_RESET = 31'(((64'd2 << FRAC_BITS) + 64'd5) / 64'd10);

  // Multiply-divide unit widths.
  localparam int A_W = 34;            // first factor, signed
  localparam int B_W = 43;            // second factor, signed
  localparam int D_W = 34;            // divisor, signed
  localparam int P_W = A_W + B_W;     // product magnitude
  localparam int QB = 41;             // quotient magnitude bits before clamping
  localparam int Q_W = QB + 1;        // signed quotient
  localparam int CNT_W = $clog2(B_W);
  localparam logic [QB-1:0] QLIM_MAG = QB'(64'd1 << (QB - 1));

  // Result status codes.
  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_MISSING = 2'd1;
  localparam logic [1:0] STATUS_ZERO_DIV = 2'd2;

  typedef struct packed {
    logic signed [31:0] row_angle;
    logic signed [31:0] row_w2;
    logic signed [31:0] row_value;
    logic               end_of_table;
  } row_req_t;

  typedef struct packed {
    logic signed [31:0] interpolated_value;
    logic [1:0]         status;
  } result_t;

  typedef struct packed {
    logic                  start;
    logic signed [A_W-1:0] a;
    logic signed [B_W-1:0] b;
    logic signed [D_W-1:0] d;
  } md_req_t;

  typedef struct packed {
    logic                  done;
    logic                  zero;
    logic signed [Q_W-1:0] q;
  } md_rsp_t;

  typedef enum logic [2:0] {
    MD_IDLE,
    MD_MUL,
    MD_DSET,
    MD_DIV,
    MD_FIN,
    MD_DONE
  } md_state_t;

  typedef enum logic [1:0] {
    ST_SCAN,
    ST_LAUNCH,
    ST_WAIT,
    ST_FINISH
  } scan_state_t;

  typedef enum logic [1:0] {
    PH_LOW,
    PH_HIGH,
    PH_ANGLE
  } phase_t;

endpackage

`default_nettype wire

/* rtl/tsbi_muldiv.sv */
`timescale 1ns / 1ps
`default_nettype none

// trunc(a*b/d) clamped to +-2^40: shift-add multiply, then restoring divide.
module tsbi_muldiv import tsbi_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire md_req_t req,
  output md_rsp_t      rsp
);

  md_state_t state, state_next;

  logic [A_W-1:0]       ma;
  logic [D_W-1:0]       md;
  logic [P_W-1:0]       p;
  logic [D_W-1:0]       r;
  logic [QB-1:0]        q;
  logic [CNT_W-1:0]     cnt;
  logic                 neg;
  logic                 zero;
  logic signed [Q_W-1:0] q_out;

  logic [A_W-1:0]       a_mag;
  logic [B_W-1:0]       b_mag;
  logic [D_W-1:0]       d_mag;
  logic [A_W:0]         mul_sum;
  logic [P_W-QB-1:0]    hi;
  logic [D_W:0]         trial;
  logic                 fits;
  logic [QB-1:0]        q_sat;

  assign a_mag = req.a[A_W-1] ? $unsigned(-req.a) : $unsigned(req.a);
  assign b_mag = req.b[B_W-1] ? $unsigned(-req.b) : $unsigned(req.b);
  assign d_mag = req.d[D_W-1] ? $unsigned(-req.d) : $unsigned(req.d);

  assign mul_sum = {1'b0, p[P_W-1:B_W]} + (p[0] ? {1'b0, ma} : '0);
  assign hi = p[P_W-1:QB];
  assign trial = {r, p[QB-1]};
  assign fits = trial >= {1'b0, md};
  assign q_sat = (q > QLIM_MAG) ? QLIM_MAG : q;

  always_comb begin
    state_next = state;
    case (state)
      MD_IDLE: begin
        if (req.start) begin
          state_next = (d_mag == '0) ? MD_DONE : MD_MUL;
        end
      end
      MD_MUL: begin
        if (cnt == CNT_W'(B_W - 1)) begin
          state_next = MD_DSET;
        end
      end
      MD_DSET: begin
        state_next = (hi >= (P_W-QB)'(md)) ? MD_DONE : MD_DIV;
      end
      MD_DIV: begin
        if (cnt == CNT_W'(QB - 1)) begin
          state_next = MD_FIN;
        end
      end
      MD_FIN:  state_next = MD_DONE;
      MD_DONE: state_next = MD_IDLE;
      default: state_next = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      MD_IDLE: begin
        if (req.start) begin
          ma   <= a_mag;
          md   <= d_mag;
          p    <= {{A_W{1'b0}}, b_mag};
          cnt  <= '0;
          neg  <= req.a[A_W-1] ^ req.b[B_W-1] ^ req.d[D_W-1];
          zero <= (d_mag == '0);
          // Zero divisor: zero for a zero dividend, else saturate by the sign of the dividend.
          if (a_mag == '0 || b_mag == '0) begin
            q_out <= '0;
          end else if (req.a[A_W-1] ^ req.b[B_W-1]) begin
            q_out <= -$signed({1'b0, QLIM_MAG});
          end else begin
            q_out <= $signed({1'b0, QLIM_MAG});
          end
        end
      end
      MD_MUL: begin
        p   <= {mul_sum, p[B_W-1:1]};
        cnt <= cnt + 1'b1;
      end
      MD_DSET: begin
        r   <= hi[D_W-1:0];
        cnt <= '0;
        q   <= '0;
        q_out <= neg ? -$signed({1'b0, QLIM_MAG}) : $signed({1'b0, QLIM_MAG});
      end
      MD_DIV: begin
        r   <= fits ? D_W'(trial - {1'b0, md}) : trial[D_W-1:0];
        q   <= {q[QB-2:0], fits};
        p   <= {p[P_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
      end
      MD_FIN: begin
        q_out <= neg ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});
      end
      default: begin
      end
    endcase
  end

  assign rsp.done = (state == MD_DONE);
  assign rsp.zero = zero;
  assign rsp.q    = q_out;

endmodule

`default_nettype wire

/* rtl/table_scan_bilinear_interp_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Bilinear interpolation over a streamed table. Rows (angle, w2, value, all
// signed Q16.16) arrive one per request and are taken one per cycle while the
// table is scanned. The first row whose angle is within angle_tolerance of
// query_angle fixes the low angle, a later different angle within tolerance
// the high angle; on each angle the first row with w2 below query_w2 and the
// row before it form an edge. The scan ends on the high edge, on
// end_of_table, or on a row with a non-positive angle (that row is not used).
// Then a result is made: interpolation in w2 on each edge, then in angle,
// each a multiply-divide in a single shared shift-add / restoring-divide unit,
// and the input is held off meanwhile; with corners missing the result
// (status 1, value 0) is made without the unit. A zero divisor gives status
// 2 with a saturated quotient, or zero for a zero dividend. If the
// ending row was not end_of_table, later rows are dropped up to and including
// the next end_of_table row. The result sits in an output register, so the
// next scan proceeds while it waits. Configuration writes take effect at once
// and are meant for idle periods only.
module table_scan_bilinear_interp_core import tsbi_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire row_req_t    in_req,
  output logic             out_valid,
  input  wire logic        out_ready,
  output result_t          out_res
);

  localparam logic [1:0] REG_QUERY_ANGLE = 2'd0;
  localparam logic [1:0] REG_QUERY_W2    = 2'd1;
  localparam logic [1:0] REG_TOLERANCE   = 2'd2;

  localparam logic signed [42:0] EDGE_MAX = 43'sd1 <<< 40;
  localparam logic signed [42:0] EDGE_MIN = -(43'sd1 <<< 40);
  localparam logic signed [42:0] RES_MAX  = 43'sd2147483647;
  localparam logic signed [42:0] RES_MIN  = -43'sd2147483648;

  // Query registers.
  logic signed [31:0] query_angle;
  logic signed [31:0] query_w2;
  logic [30:0]        angle_tolerance;

  // Scan state.
  logic               low_angle_found, high_angle_found;
  logic               low_edge_found, high_edge_found;
  logic               result_sent;
  logic signed [31:0] low_angle, high_angle;
  logic signed [31:0] previous_w2, previous_value;
  logic signed [31:0] edge_w2 [4];
  logic signed [31:0] edge_value [4];

  // Result sequencing.
  scan_state_t        state, state_next;
  phase_t             phase;
  logic               eot_pending;
  logic               missing;
  logic               zero_seen;
  logic signed [41:0] edge_lo, edge_hi;
  logic signed [31:0] res;

  md_req_t            md_req;
  md_rsp_t            md_rsp;
  logic               md_start;

  // Row evaluation, in the order: low angle, low edge, high angle, high edge.
  logic               in_fire, row_live, row_pos, scan_end, clear_scan, finish_fire;
  logic signed [32:0] adiff;
  logic [32:0]        amag;
  logic               near, below;
  logic               laf_n, hef_n;
  logic signed [31:0] la_n, ha_n;
  logic               cap_lo, set_hi, cap_hi;
  logic signed [42:0] edge_sum, res_sum;
  logic signed [31:0] z0;

  assign in_fire  = in_valid && in_ready;
  assign row_live = in_fire && !result_sent;
  assign row_pos  = !in_req.row_angle[31] && (in_req.row_angle != '0);

  assign adiff = 33'(query_angle) - 33'(in_req.row_angle);
  assign amag  = adiff[32] ? $unsigned(-adiff) : $unsigned(adiff);
  assign near  = amag <= {2'b00, angle_tolerance};
  assign below = in_req.row_w2 < query_w2;

  // A non-positive row is not processed, so it captures no edge.
  always_comb begin
    laf_n = low_angle_found;
    la_n  = low_angle;
    if (!low_angle_found && near) begin
      laf_n = 1'b1;
      la_n  = in_req.row_angle;
    end
    cap_lo = row_pos && laf_n && (in_req.row_angle == la_n) && below && !low_edge_found;
    set_hi = !high_angle_found && near && (in_req.row_angle != la_n);
    ha_n   = set_hi ? in_req.row_angle : high_angle;
    cap_hi = row_pos && (high_angle_found || set_hi) && (in_req.row_angle == ha_n)
             && below && !high_edge_found;
    hef_n  = high_edge_found || cap_hi;
  end

  assign scan_end = row_live && (!row_pos || hef_n || in_req.end_of_table);
  assign finish_fire = (state == ST_FINISH) && (!out_valid || out_ready);
  assign clear_scan = (in_fire && result_sent && in_req.end_of_table)
                      || (finish_fire && eot_pending);

  // Next state and unit control.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    md_start   = 1'b0;
    case (state)
      ST_SCAN: begin
        in_ready = 1'b1;
        if (scan_end) begin
          state_next = (low_edge_found || cap_lo) && hef_n ? ST_LAUNCH : ST_FINISH;
        end
      end
      ST_LAUNCH: begin
        md_start   = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (md_rsp.done) begin
          state_next = (phase == PH_ANGLE) ? ST_FINISH : ST_LAUNCH;
        end
      end
      ST_FINISH: begin
        if (finish_fire) begin
          state_next = ST_SCAN;
        end
      end
      default: state_next = ST_SCAN;
    endcase
  end

  // Operands for the shared multiply-divide.
  always_comb begin
    md_req.start = md_start;
    case (phase)
      PH_LOW: begin
        md_req.a = A_W'(query_w2) - A_W'(edge_w2[0]);
        md_req.b = B_W'(edge_value[1]) - B_W'(edge_value[0]);
        md_req.d = D_W'(edge_w2[1]) - D_W'(edge_w2[0]);
      end
      PH_HIGH: begin
        md_req.a = A_W'(query_w2) - A_W'(edge_w2[2]);
        md_req.b = B_W'(edge_value[3]) - B_W'(edge_value[2]);
        md_req.d = D_W'(edge_w2[3]) - D_W'(edge_w2[2]);
      end
      PH_ANGLE: begin
        md_req.a = A_W'(query_angle) - A_W'(low_angle);
        md_req.b = B_W'(edge_hi) - B_W'(edge_lo);
        md_req.d = D_W'(high_angle) - D_W'(low_angle);
      end
      default: begin
        md_req.a = '0;
        md_req.b = '0;
        md_req.d = '0;
      end
    endcase
  end

  assign z0       = (phase == PH_LOW) ? edge_value[0] : edge_value[2];
  assign edge_sum = 43'(z0) + 43'(md_rsp.q);
  assign res_sum  = 43'(edge_lo) + 43'(md_rsp.q);

  tsbi_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SCAN;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      query_angle     <= QUERY_ANGLE_RESET;
      query_w2        <= QUERY_W2_RESET;
      angle_tolerance <= TOLERANCE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_QUERY_ANGLE: query_angle     <= cfg_data;
        REG_QUERY_W2:    query_w2        <= cfg_data;
        REG_TOLERANCE:   angle_tolerance <= cfg_data[30:0];
        default: begin
        end
      endcase
    end
  end

  // Scan state: clear on reset or rearm, advance on every live positive row.
  always_ff @(posedge clk) begin
    if (rst || clear_scan) begin
      low_angle_found  <= 1'b0;
      high_angle_found <= 1'b0;
      low_edge_found   <= 1'b0;
      high_edge_found  <= 1'b0;
      result_sent      <= 1'b0;
      low_angle        <= MINUS_ONE;
      high_angle       <= MINUS_ONE;
      previous_w2      <= MINUS_ONE;
      previous_value   <= MINUS_ONE;
      for (int i = 0; i < 4; i++) begin
        edge_w2[i]    <= MINUS_ONE;
        edge_value[i] <= MINUS_ONE;
      end
    end else begin
      if (row_live && row_pos) begin
        low_angle_found  <= laf_n;
        low_angle        <= la_n;
        high_angle_found <= high_angle_found || set_hi;
        high_angle       <= ha_n;
        high_edge_found  <= hef_n;
        if (cap_lo) begin
          low_edge_found <= 1'b1;
          edge_w2[0]     <= in_req.row_w2;
          edge_value[0]  <= in_req.row_value;
          edge_w2[1]     <= previous_w2;
          edge_value[1]  <= previous_value;
        end
        if (cap_hi) begin
          edge_w2[2]    <= in_req.row_w2;
          edge_value[2] <= in_req.row_value;
          edge_w2[3]    <= previous_w2;
          edge_value[3] <= previous_value;
        end
        previous_w2    <= in_req.row_w2;
        previous_value <= in_req.row_value;
      end
      // Drop rows until end_of_table once a result has gone out mid-table.
      if (finish_fire && !eot_pending) begin
        result_sent <= 1'b1;
      end
    end
  end

  // Result sequencing.
  always_ff @(posedge clk) begin
    if (scan_end) begin
      eot_pending <= in_req.end_of_table;
      missing     <= !((low_edge_found || cap_lo) && hef_n);
      zero_seen   <= 1'b0;
      phase       <= PH_LOW;
    end else if (state == ST_WAIT && md_rsp.done) begin
      zero_seen <= zero_seen || md_rsp.zero;
      case (phase)
        PH_LOW: begin
          edge_lo <= (edge_sum > EDGE_MAX) ? EDGE_MAX[41:0]
                   : (edge_sum < EDGE_MIN) ? EDGE_MIN[41:0] : edge_sum[41:0];
          phase   <= PH_HIGH;
        end
        PH_HIGH: begin
          edge_hi <= (edge_sum > EDGE_MAX) ? EDGE_MAX[41:0]
                   : (edge_sum < EDGE_MIN) ? EDGE_MIN[41:0] : edge_sum[41:0];
          phase   <= PH_ANGLE;
        end
        default: begin
          res <= (res_sum > RES_MAX) ? RES_MAX[31:0]
               : (res_sum < RES_MIN) ? RES_MIN[31:0] : res_sum[31:0];
        end
      endcase
    end
  end

  // Output register: hold until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_fire) begin
      out_res.interpolated_value <= missing ? '0 : res;
      out_res.status <= missing ? STATUS_MISSING
                      : (zero_seen ? STATUS_ZERO_DIV : STATUS_OK);
    end
  end

endmodule

`default_nettype wire

/* rtl/tsbi_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module tsbi_checker import tsbi_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire result_t     out_res
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_res))
    else $error("stalled result changed or dropped");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_res.status == STATUS_OK || out_res.status == STATUS_MISSING
                   || out_res.status == STATUS_ZERO_DIV))
    else $error("illegal status code");

  a_missing_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.status == STATUS_MISSING |-> out_res.interpolated_value == '0)
    else $error("missing corners with nonzero value");

  // A new result is only produced while requests are held off.
  a_result_after_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while scanning");

endmodule

bind table_scan_bilinear_interp_core tsbi_checker u_tsbi_checker (.*);

`default_nettype wire
